// ===== hdl/life_pkg.sv =====
// Shared types and constants for the toroidal Life step unit.
package life_pkg;

  // Default grid bounds
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_STEP  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_IN_PLACE  = 2'd2;

  // Register reset values
  localparam logic [6:0] ROW_COUNT_RST = 7'd64;
  localparam logic [6:0] COL_COUNT_RST = 7'd64;

  // Life rule neighbor counts
  localparam logic [3:0] SURVIVE_N = 4'd2;
  localparam logic [3:0] BIRTH_N   = 4'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       write_value;
  } life_in_t;

  typedef struct packed {
    logic       read_value;
    logic [1:0] done_cmd;
    logic       out_of_range;
  } life_out_t;

endpackage

// ===== hdl/life_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module life_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/life_automaton_torus_step_unit.sv =====
// Top level of the toroidal Life step unit: command sequencer, grid RAMs, rule unit.
// Clear: one RAM write per cycle over the whole store (MAX_ROWS*MAX_COLS cells).
// Step: per active cell, nine reads through the one grid read port, then the update;
//   then, in double-buffer mode, a copy of the rows*cols active cells; then the report.
// One command at a time; a finished result waits in the output register while the next
//   item is accepted. After reset, req_stall stays high during a clearing pass over the
//   grid; configuration writes are taken throughout.
module life_automaton_torus_step_unit #(
  parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  life_pkg::life_in_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output life_pkg::life_out_t rsp
);

  import life_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ_WAIT, S_STEP_RD, S_STEP_LAST, S_COPY_RD, S_COPY_LAST, S_DONE
  } state_t;

  state_t           state;
  logic [6:0]       row_count;
  logic [6:0]       col_count;
  logic             in_place_mode;
  logic [AW-1:0]    clr_addr;
  logic             clr_reply;
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    cur_col;
  logic [1:0]       dr;
  logic [1:0]       dc;
  logic [3:0]       count;
  logic             alive;
  logic             rd_pend;
  logic             prev_self;
  logic [AW-1:0]    copy_addr;
  life_out_t        res;

  logic [RCW-1:0]   act_rows;
  logic [CCW-1:0]   act_cols;
  logic [RW-1:0]    last_row;
  logic [CW-1:0]    last_col;
  logic [RW-1:0]    sel_row;
  logic [CW-1:0]    sel_col;
  logic [AW-1:0]    cell_addr;
  logic [AW-1:0]    nb_addr;
  logic [AW-1:0]    req_addr;
  logic             req_in_range;
  logic [3:0]       n_total;
  logic             next_alive;

  logic             now_we;
  logic [AW-1:0]    now_waddr;
  logic             now_wdata;
  logic [AW-1:0]    now_raddr;
  logic [0:0]       now_rdata;
  logic             nx_we;
  logic [AW-1:0]    nx_waddr;
  logic [AW-1:0]    nx_raddr;
  logic [0:0]       nx_rdata;

  // Clamp the active grid size to 1..MAX
  always_comb begin
    if (row_count == '0) begin
      act_rows = RCW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      act_rows = RCW'(MAX_ROWS);
    end else begin
      act_rows = RCW'(row_count);
    end
    if (col_count == '0) begin
      act_cols = CCW'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      act_cols = CCW'(MAX_COLS);
    end else begin
      act_cols = CCW'(col_count);
    end
  end

  assign last_row = RW'(act_rows - RCW'(1));
  assign last_col = CW'(act_cols - CCW'(1));

  // Pick the wrapped neighbor row and column for the current read slot
  always_comb begin
    case (dr)
      2'd0:    sel_row = (cur_row == '0) ? last_row : RW'(cur_row - RW'(1));
      2'd1:    sel_row = cur_row;
      default: sel_row = (cur_row == last_row) ? '0 : RW'(cur_row + RW'(1));
    endcase
    case (dc)
      2'd0:    sel_col = (cur_col == '0) ? last_col : CW'(cur_col - CW'(1));
      2'd1:    sel_col = cur_col;
      default: sel_col = (cur_col == last_col) ? '0 : CW'(cur_col + CW'(1));
    endcase
  end

  assign cell_addr = AW'(32'(cur_row) * MAX_COLS + 32'(cur_col));
  assign nb_addr   = AW'(32'(sel_row) * MAX_COLS + 32'(sel_col));
  assign req_addr  = AW'(32'(req.cell_row) * MAX_COLS + 32'(req.cell_col));
  assign req_in_range = (32'(req.cell_row) < 32'(act_rows)) &&
                        (32'(req.cell_col) < 32'(act_cols));

  // Apply the Life rule to the finished neighbor count
  assign n_total    = count + 4'(now_rdata[0]);
  assign next_alive = alive ? ((n_total == SURVIVE_N) || (n_total == BIRTH_N))
                            : (n_total == BIRTH_N);

  assign req_stall = (state != S_IDLE);

  // Steer the RAM ports by sequencer state
  always_comb begin
    now_we    = 1'b0;
    now_waddr = cell_addr;
    now_wdata = 1'b0;
    now_raddr = nb_addr;
    nx_we     = 1'b0;
    nx_waddr  = cell_addr;
    nx_raddr  = cell_addr;
    case (state)
      S_CLEAR: begin
        now_we    = 1'b1;
        now_waddr = clr_addr;
      end
      S_IDLE: begin
        now_raddr = req_addr;
        if (req_valid && (req.cmd == CMD_WRITE) && req_in_range) begin
          now_we    = 1'b1;
          now_waddr = req_addr;
          now_wdata = req.write_value;
        end
      end
      S_STEP_LAST: begin
        if (in_place_mode) begin
          now_we    = 1'b1;
          now_wdata = next_alive;
        end else begin
          nx_we = 1'b1;
        end
      end
      S_COPY_RD: begin
        if (rd_pend) begin
          now_we    = 1'b1;
          now_waddr = copy_addr;
          now_wdata = nx_rdata[0];
        end
      end
      S_COPY_LAST: begin
        now_we    = 1'b1;
        now_waddr = copy_addr;
        now_wdata = nx_rdata[0];
      end
      default: begin
      end
    endcase
  end

  life_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid_now (
    .clk   (clk),
    .we    (now_we),
    .waddr (now_waddr),
    .wdata (now_wdata),
    .raddr (now_raddr),
    .rdata (now_rdata)
  );

  life_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid_next (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (next_alive),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      row_count     <= ROW_COUNT_RST;
      col_count     <= COL_COUNT_RST;
      in_place_mode <= 1'b0;
      clr_addr      <= '0;
      clr_reply     <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      dr            <= '0;
      dc            <= '0;
      count         <= '0;
      rd_pend       <= 1'b0;
      prev_self     <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count     <= cfg_data;
          REG_COL_COUNT: col_count     <= cfg_data;
          REG_IN_PLACE:  in_place_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // Drop the result once taken
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= AW'(clr_addr + AW'(1));
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            res.done_cmd     <= req.cmd;
            res.read_value   <= 1'b0;
            res.out_of_range <= 1'b0;
            case (req.cmd)
              CMD_WRITE: begin
                res.out_of_range <= !req_in_range;
                state            <= S_DONE;
              end
              CMD_READ: begin
                if (req_in_range) begin
                  state <= S_READ_WAIT;
                end else begin
                  res.out_of_range <= 1'b1;
                  state            <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                clr_reply <= 1'b1;
                clr_addr  <= '0;
                state     <= S_CLEAR;
              end
              default: begin
                cur_row   <= '0;
                cur_col   <= '0;
                dr        <= '0;
                dc        <= '0;
                count     <= '0;
                rd_pend   <= 1'b0;
                prev_self <= 1'b0;
                state     <= S_STEP_RD;
              end
            endcase
          end
        end

        S_READ_WAIT: begin
          res.read_value <= now_rdata[0];
          state          <= S_DONE;
        end

        // Issue one neighbor read a cycle; add each word that lands to the count, but keep the center as the cell state
        S_STEP_RD: begin
          rd_pend   <= 1'b1;
          prev_self <= (dr == 2'd1) && (dc == 2'd1);
          if (rd_pend) begin
            if (prev_self) begin
              alive <= now_rdata[0];
            end else begin
              count <= n_total;
            end
          end
          if (dc == 2'd2) begin
            dc <= '0;
            if (dr == 2'd2) begin
              dr    <= '0;
              state <= S_STEP_LAST;
            end else begin
              dr <= dr + 2'd1;
            end
          end else begin
            dc <= dc + 2'd1;
          end
        end

        // Write the new cell state and advance in raster order
        S_STEP_LAST: begin
          rd_pend   <= 1'b0;
          prev_self <= 1'b0;
          count     <= '0;
          state     <= S_STEP_RD;
          if (cur_col == last_col) begin
            cur_col <= '0;
            if (cur_row == last_row) begin
              cur_row <= '0;
              state   <= in_place_mode ? S_DONE : S_COPY_RD;
            end else begin
              cur_row <= RW'(cur_row + RW'(1));
            end
          end else begin
            cur_col <= CW'(cur_col + CW'(1));
          end
        end

        // Copy the new generation back, one cell a cycle
        S_COPY_RD: begin
          rd_pend   <= 1'b1;
          copy_addr <= cell_addr;
          if (cur_col == last_col) begin
            cur_col <= '0;
            if (cur_row == last_row) begin
              cur_row <= '0;
              state   <= S_COPY_LAST;
            end else begin
              cur_row <= RW'(cur_row + RW'(1));
            end
          end else begin
            cur_col <= CW'(cur_col + CW'(1));
          end
        end

        S_COPY_LAST: begin
          rd_pend <= 1'b0;
          state   <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Seven non-center neighbors are summed before the last read lands
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP_LAST) |-> (count <= 4'd7))
    else $error("neighbor count overflow before last read");

  // An accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("accepted item did not start");

  // A result is posted whenever the output register can take it
  a_post_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && state == S_IDLE))
    else $error("result not posted");

  // The back buffer is never written while it is copied
  a_copy_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY_RD || state == S_COPY_LAST) |-> !nx_we)
    else $error("back buffer written during copy");

  // The sweep position is back at the origin when the step ends
  a_sweep_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.done_cmd == CMD_STEP) |-> (cur_row == '0 && cur_col == '0))
    else $error("sweep position not returned to origin");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the toroidal Life step unit, with a cell-level predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import life_pkg::*;

  localparam int GRID_CELLS  = MAX_ROWS_DEF * MAX_COLS_DEF;
  // The longest silent stretch is one full 64x64 step
  localparam int QUIET_LIMIT = 200_000;
  localparam int GAP_PERCENT = 11;

  logic      clk;
  logic      rst       = 1'b1;
  logic      cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_ROW_COUNT;
  logic [6:0] cfg_data  = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  life_in_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  life_out_t rsp;

  // Predictor state: grid as stored by address row*MAX_COLS+col, plus registers
  bit [GRID_CELLS-1:0] cell_now = '0;
  bit [GRID_CELLS-1:0] cell_next = '0;
  bit [6:0] rows_reg     = ROW_COUNT_RST;
  bit [6:0] cols_reg     = COL_COUNT_RST;
  bit       in_place_reg = 1'b0;

  life_in_t  command_queue[$];
  life_out_t expected_replies[$];

  int fail_count   = 0;
  int req_count    = 0;
  int rsp_count    = 0;
  int quiet_cycles = 0;

  // Noise control for the random part
  bit noise_on  = 1'b0;
  bit big_phase = 1'b0;
  int cur_rows  = MAX_ROWS_DEF;
  int cur_cols  = MAX_COLS_DEF;

  life_automaton_torus_step_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp register values to the usable grid size
  function automatic int grid_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  function automatic int grid_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(cols_reg);
  endfunction

  // Count the eight wrapped neighbors; repeats on tiny grids count each time
  function automatic int live_neighbors(int r, int c, int nrows, int ncols);
    int total;
    int rr;
    int cc;
    total = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        rr = (r + dr + nrows) % nrows;
        cc = (c + dc + ncols) % ncols;
        total += int'(cell_now[rr * MAX_COLS_DEF + cc]);
      end
    end
    return total;
  endfunction

  // Sweep the active area in raster order, then copy back unless updating in place
  function automatic void advance_generation();
    int nrows;
    int ncols;
    int addr;
    int n;
    bit new_state;
    nrows = grid_rows();
    ncols = grid_cols();
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        addr = r * MAX_COLS_DEF + c;
        n = live_neighbors(r, c, nrows, ncols);
        if (cell_now[addr]) new_state = (n == int'(SURVIVE_N)) || (n == int'(BIRTH_N));
        else new_state = (n == int'(BIRTH_N));
        if (in_place_reg) cell_now[addr] = new_state;
        else cell_next[addr] = new_state;
      end
    end
    if (!in_place_reg) begin
      for (int r = 0; r < nrows; r++) begin
        for (int c = 0; c < ncols; c++) begin
          cell_now[r * MAX_COLS_DEF + c] = cell_next[r * MAX_COLS_DEF + c];
        end
      end
    end
  endfunction

  // Apply one command to the predicted grid and return the reply it should give
  function automatic life_out_t apply_command(life_in_t item);
    life_out_t reply;
    int addr;
    reply = '0;
    reply.done_cmd = item.cmd;
    case (item.cmd)
      CMD_WRITE, CMD_READ: begin
        if (int'(item.cell_row) >= grid_rows() || int'(item.cell_col) >= grid_cols()) begin
          reply.out_of_range = 1'b1;
        end else begin
          addr = int'(item.cell_row) * MAX_COLS_DEF + int'(item.cell_col);
          if (item.cmd == CMD_WRITE) cell_now[addr] = item.write_value;
          else reply.read_value = cell_now[addr];
        end
      end
      CMD_CLEAR: cell_now = '0;
      default: advance_generation();
    endcase
    return reply;
  endfunction

  // Queue one command, sometimes preceded by a noise item
  task automatic add_request(logic [1:0] op, int r, int c, bit v);
    life_in_t item;
    if (noise_on && $urandom_range(99) < 15) begin
      item.cmd         = big_phase ? 2'($urandom_range(1)) : 2'($urandom_range(3));
      item.cell_row    = 6'($urandom_range(63));
      item.cell_col    = 6'($urandom_range(63));
      item.write_value = 1'($urandom_range(1));
      // Push an access outside the active grid where the size allows it
      if (item.cmd <= CMD_READ && $urandom_range(1) == 1) begin
        if (cur_rows < MAX_ROWS_DEF) item.cell_row = 6'($urandom_range(cur_rows, 63));
        else if (cur_cols < MAX_COLS_DEF) item.cell_col = 6'($urandom_range(cur_cols, 63));
      end
      command_queue.push_back(item);
    end
    item.cmd         = op;
    item.cell_row    = 6'(r);
    item.cell_col    = 6'(c);
    item.write_value = v;
    command_queue.push_back(item);
  endtask

  // Hold until every queued item is sent and every reply has come back
  task automatic wait_idle();
    @(negedge clk);
    while (command_queue.size() != 0 || req_valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  // Write all three registers back to back, then drop the enable
  task automatic set_registers(bit [6:0] rows_v, bit [6:0] cols_v, bit mode_v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows_v;
    rows_reg = rows_v;
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_data  <= cols_v;
    cols_reg = cols_v;
    @(posedge clk);
    cfg_index <= REG_IN_PLACE;
    cfg_data  <= {6'd0, mode_v};
    in_place_reg = mode_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_rows = grid_rows();
    cur_cols = grid_cols();
  endtask

  // Driver: predict on acceptance, then load the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_replies.push_back(apply_command(req));
        req_count++;
      end
      if (!req_valid || !req_stall) begin
        if (command_queue.size() != 0 &&
            ((req_count >= 60 && req_count < 100) || $urandom_range(99) >= GAP_PERCENT)) begin
          req_valid <= 1'b1;
          req       <= command_queue.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each accepted reply with the oldest prediction
  always @(posedge clk) begin : reply_check
    life_out_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !(rsp_count >= 60 && rsp_count < 100) &&
                   ($urandom_range(99) < GAP_PERCENT);
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (expected_replies.size() == 0) begin
          $error("reply with no command outstanding: %p", rsp);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.done_cmd !== want.done_cmd) begin
            $error("done_cmd: expected %0d, got %0d", want.done_cmd, rsp.done_cmd);
            fail_count++;
          end
          if (rsp.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   rsp.out_of_range);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int wr;
    int wc;
    bit [6:0] rows_v;
    bit [6:0] cols_v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Horizontal blinker across the column seam of the full default grid
    add_request(CMD_WRITE, 0, 63, 1'b1);
    add_request(CMD_WRITE, 0, 0, 1'b1);
    add_request(CMD_WRITE, 0, 1, 1'b1);
    add_request(CMD_READ, 0, 0, 1'b0);
    add_request(CMD_STEP, 63, 63, 1'b1);
    // It should turn vertical across the row seam
    add_request(CMD_READ, 63, 0, 1'b1);
    add_request(CMD_READ, 1, 0, 1'b0);
    add_request(CMD_READ, 0, 63, 1'b1);
    add_request(CMD_READ, 63, 63, 1'b0);
    add_request(CMD_CLEAR, 63, 63, 1'b1);
    add_request(CMD_READ, 1, 0, 1'b0);
    wait_idle();

    // Zero registers act as a 1x1 grid: a lone cell sees itself eight times
    set_registers(7'd0, 7'd0, 1'b1);
    add_request(CMD_WRITE, 0, 0, 1'b1);
    add_request(CMD_STEP, 0, 0, 1'b0);
    add_request(CMD_READ, 0, 0, 1'b0);
    add_request(CMD_WRITE, 1, 0, 1'b1);
    add_request(CMD_READ, 0, 1, 1'b0);
    add_request(CMD_WRITE, 63, 63, 1'b1);
    wait_idle();

    // Oversized row count clamps to the maximum; two columns repeat neighbors
    set_registers(7'd127, 7'd2, 1'b0);
    add_request(CMD_WRITE, 5, 0, 1'b1);
    add_request(CMD_WRITE, 5, 1, 1'b1);
    add_request(CMD_WRITE, 6, 0, 1'b1);
    add_request(CMD_STEP, 0, 0, 1'b0);
    add_request(CMD_READ, 5, 0, 1'b0);
    add_request(CMD_READ, 6, 1, 1'b0);
    add_request(CMD_READ, 0, 2, 1'b0);
    wait_idle();

    // Random phases: seed a small window, step, then read the neighborhood back
    noise_on = 1'b1;
    for (int phase = 0; phase < 7; phase++) begin
      big_phase = (phase == 4);
      if (big_phase) begin
        rows_v = 7'($urandom_range(64, 127));
        cols_v = 7'($urandom_range(64, 127));
      end else begin
        case ($urandom_range(3))
          0: begin
            rows_v = 7'($urandom_range(0, 3));
            cols_v = 7'($urandom_range(0, 127));
          end
          1: begin
            rows_v = 7'($urandom_range(0, 127));
            cols_v = 7'($urandom_range(0, 3));
          end
          default: begin
            rows_v = 7'($urandom_range(3, 12));
            cols_v = 7'($urandom_range(3, 12));
          end
        endcase
      end
      set_registers(rows_v, cols_v, 1'($urandom_range(1)));
      if ($urandom_range(3) == 0)
        add_request(CMD_CLEAR, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      wr = $urandom_range(cur_rows - 1);
      wc = $urandom_range(cur_cols - 1);
      repeat ($urandom_range(4, 8))
        add_request(CMD_WRITE, (wr + $urandom_range(3)) % cur_rows,
                    (wc + $urandom_range(3)) % cur_cols, $urandom_range(99) < 80);
      repeat (big_phase ? 1 : $urandom_range(1, 3))
        add_request(CMD_STEP, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      repeat ($urandom_range(5, 8))
        add_request(CMD_READ, (wr + cur_rows - 1 + $urandom_range(5)) % cur_rows,
                    (wc + cur_cols - 1 + $urandom_range(5)) % cur_cols,
                    1'($urandom_range(1)));
      wait_idle();
    end

    // Let any stray reply show up before judging
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
